/* rtl/nnu_pkg.sv */
// Shared sizes, codes and types of the nearest-neighbor upscaler.
package nnu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_FACTOR = 8;

  // Fixed field widths
  localparam int ZOOM_W  = 4;
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int CIDX_W  = 2;

  // Derived counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int FACT_W = $clog2(MAX_FACTOR + 1);
  localparam int RL_W   = $clog2(MAX_FACTOR);

  localparam logic [ZOOM_W-1:0] ZOOM_RESET  = ZOOM_W'(1);
  localparam logic [SIZE_W-1:0] WIDTH_RESET = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(512);

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_ZOOM   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // One pending item handed from the sequencer to the replicator
  typedef struct packed {
    logic              valid;
    logic              err;
    logic              use_ram;
    logic [PIX_W-1:0]  pixel;
    logic              row_end;
    logic              frame_end;
    logic [FACT_W-1:0] copies;
  } desc_t;

endpackage

/* rtl/nearest_neighbor_upscaler.sv */
// Top level of the nearest-neighbor integer upscaler.
// Push items (opcode 0) carry source pixels in raster order; each is stored
// in a one-row line store and leaves at once as zoom_factor copies (a
// zoom_factor above 8 counts as 8). After each source row the user sends
// zoom_factor-1 replay rows of replay items (opcode 1), one per source
// column; each replays the stored pixel as zoom_factor copies. An item out
// of order gives a single result with order_error set and changes nothing;
// with zoom_factor 0 items are taken and give no result. Results leave one
// per cycle while out_ready is high. The item register frees when the
// replicator takes its item, so it can hold the next item while the
// replicator sends the copies of the last; the copy counter in the
// replicator sets the sustained rate (with the output always ready, one
// item per cycle at factor 1, for out-of-order items and at factor 0). The
// edge that takes an item loads the item register (and starts the line
// store read); the result register loads when the replicator takes the
// item, and then holds the first copy. A register write restarts the frame
// at row 0 and must be made while the block is idle.
module nearest_neighbor_upscaler import nnu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // input items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [PIX_W-1:0]  pixel_in,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIX_W-1:0]  pixel_out,
  output logic              row_end,
  output logic              frame_end,
  output logic              run_last,
  output logic              order_error
);

  desc_t            desc;
  logic             take;
  logic             ram_we, ram_re;
  logic [COL_W-1:0] ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  // Sequencer: order check, raster counters, item register
  nnu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .pixel_in  (pixel_in),
    .take      (take),
    .desc      (desc),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // Line store; read data stays put until the next replay read
  nnu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Replicator and result register
  nnu_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .desc        (desc),
    .ram_rdata   (ram_rdata),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_out   (pixel_out),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .run_last    (run_last),
    .order_error (order_error)
  );

endmodule

/* rtl/nnu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nnu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/nnu_ctrl.sv */
// Configuration registers, raster position counters and the item register.
module nnu_ctrl import nnu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              opcode,
  input  logic [PIX_W-1:0]  pixel_in,
  input  logic              take,
  output desc_t             desc,
  output logic              ram_we,
  output logic [COL_W-1:0]  ram_waddr,
  output logic [PIX_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [COL_W-1:0]  ram_raddr
);

  logic [ZOOM_W-1:0] zoom_factor;
  logic [SIZE_W-1:0] source_width;
  logic [SIZE_W-1:0] source_height;

  logic [COL_W-1:0] source_column;
  logic [ROW_W-1:0] source_row;
  logic [RL_W-1:0]  replay_rows_left;
  logic [COL_W-1:0] replay_column;

  logic [FACT_W-1:0] f_eff;
  logic [WCNT_W-1:0] w_eff;
  logic [HCNT_W-1:0] h_eff;
  logic              fire, act, err, row_last, row_wrap;
  logic [COL_W-1:0]  col;
  desc_t             desc_next;

  // Effective sizes after clamping
  always_comb begin
    if (int'(zoom_factor) > MAX_FACTOR) f_eff = FACT_W'(MAX_FACTOR);
    else                                f_eff = FACT_W'(zoom_factor);
    if (source_width == '0)                   w_eff = WCNT_W'(1);
    else if (int'(source_width) > MAX_WIDTH)  w_eff = WCNT_W'(MAX_WIDTH);
    else                                      w_eff = WCNT_W'(source_width);
    if (source_height == '0)                  h_eff = HCNT_W'(1);
    else if (int'(source_height) > MAX_HEIGHT) h_eff = HCNT_W'(MAX_HEIGHT);
    else                                      h_eff = HCNT_W'(source_height);
  end

  assign in_ready = !desc.valid || take;
  assign fire     = in_valid && in_ready;
  assign act      = fire && (f_eff != '0);
  assign err      = (opcode == OP_PUSH) != (replay_rows_left == '0);
  assign col      = (opcode == OP_PUSH) ? source_column : replay_column;
  assign row_last = (WCNT_W'(col) + WCNT_W'(1)) == w_eff;
  assign row_wrap = (HCNT_W'(source_row) + HCNT_W'(1)) == h_eff;

  assign ram_we    = act && !err && (opcode == OP_PUSH);
  assign ram_waddr = source_column;
  assign ram_wdata = pixel_in;
  assign ram_re    = act && !err && (opcode == OP_REPLAY);
  assign ram_raddr = replay_column;

  always_comb begin
    desc_next.valid     = 1'b1;
    desc_next.err       = err;
    desc_next.use_ram   = !err && (opcode == OP_REPLAY);
    desc_next.pixel     = err ? '0 : pixel_in;
    desc_next.copies    = err ? FACT_W'(1) : f_eff;
    desc_next.row_end   = !err && row_last;
    if (opcode == OP_PUSH) begin
      desc_next.frame_end = !err && row_last && (f_eff == FACT_W'(1)) && row_wrap;
    end else begin
      desc_next.frame_end = !err && row_last && (replay_rows_left == RL_W'(1)) && row_wrap;
    end
  end

  // Item register; the payload loads only with a new item
  always_ff @(posedge clk) begin
    if (rst) begin
      desc.valid <= 1'b0;
    end else if (act) begin
      desc <= desc_next;
    end else if (take) begin
      desc.valid <= 1'b0;
    end
  end

  // Registers and raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_factor      <= ZOOM_RESET;
      source_width     <= WIDTH_RESET;
      source_height    <= HEIGHT_RESET;
      source_column    <= '0;
      source_row       <= '0;
      replay_rows_left <= '0;
      replay_column    <= '0;
    end else if (cfg_we && (cfg_index <= REG_HEIGHT)) begin
      unique case (cfg_index)
        REG_ZOOM:   zoom_factor   <= cfg_data[ZOOM_W-1:0];
        REG_WIDTH:  source_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: source_height <= cfg_data[SIZE_W-1:0];
        default:    ;
      endcase
      source_column    <= '0;
      source_row       <= '0;
      replay_rows_left <= '0;
      replay_column    <= '0;
    end else if (act && !err) begin
      if (opcode == OP_PUSH) begin
        if (row_last) begin
          source_column    <= '0;
          replay_column    <= '0;
          replay_rows_left <= RL_W'(f_eff - FACT_W'(1));
          if (f_eff == FACT_W'(1)) begin
            source_row <= row_wrap ? '0 : source_row + ROW_W'(1);
          end
        end else begin
          source_column <= source_column + COL_W'(1);
        end
      end else begin
        if (row_last) begin
          replay_column    <= '0;
          replay_rows_left <= replay_rows_left - RL_W'(1);
          if (replay_rows_left == RL_W'(1)) begin
            source_row <= row_wrap ? '0 : source_row + ROW_W'(1);
          end
        end else begin
          replay_column <= replay_column + COL_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/nnu_emit.sv */
// Output replicator: sends the copies of one item from the result register.
module nnu_emit import nnu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  desc_t            desc,
  input  logic [PIX_W-1:0] ram_rdata,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] pixel_out,
  output logic             row_end,
  output logic             frame_end,
  output logic             run_last,
  output logic             order_error
);

  logic              busy;
  logic [PIX_W-1:0]  pix;
  logic              row_flag, frame_flag, err_flag;
  logic [FACT_W-1:0] left;
  logic              last, done;

  assign last = (left == FACT_W'(1));
  assign done = busy && out_ready && last;
  assign take = desc.valid && (!busy || done);

  assign out_valid   = busy;
  assign pixel_out   = pix;
  assign run_last    = last;
  assign row_end     = row_flag && last;
  assign frame_end   = frame_flag && last;
  assign order_error = err_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix        <= desc.use_ram ? ram_rdata : desc.pixel;
      row_flag   <= desc.row_end;
      frame_flag <= desc.frame_end;
      err_flag   <= desc.err;
      left       <= desc.copies;
    end else if (busy && out_ready) begin
      left <= left - FACT_W'(1);
    end
  end

endmodule

/* rtl/nnu_checker.sv */
// Port-level checks on the upscaler result stream, bound to the top level.
module nnu_checker import nnu_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] pixel_out,
  input logic             row_end,
  input logic             frame_end,
  input logic             run_last,
  input logic             order_error
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(run_last))
    else $error("result changed while stalled");

  // error result is a lone, blank item
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && order_error |-> run_last && !row_end && !frame_end && (pixel_out == '0))
    else $error("malformed order error result");

  // frame end only closes a row
  a_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  // row end only on the last copy of an item
  a_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> run_last)
    else $error("row end before last copy");

  // copies of one item share the pixel value
  a_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> out_valid && (pixel_out == $past(pixel_out)))
    else $error("copy pixel differs");

endmodule

bind nearest_neighbor_upscaler nnu_checker u_nnu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_out   (pixel_out),
  .row_end     (row_end),
  .frame_end   (frame_end),
  .run_last    (run_last),
  .order_error (order_error)
);
